// File: rtl/afd_pkg.sv
// Shared constants and types for the angle frame deframer.
package afd_pkg;

  localparam int WIN_LEN = 11;
  localparam int CHK_POS = 4;

  localparam logic [7:0] HDR_0 = 8'hA7;
  localparam logic [7:0] HDR_1 = 8'h7A;
  localparam logic [7:0] HDR_2 = 8'h72;
  localparam logic [7:0] HDR_3 = 8'h07;

  typedef logic [7:0] byte_t;
  typedef logic [WIN_LEN-1:0][7:0] window_t;

  typedef struct packed {
    logic shift;
    logic flush;
  } afd_ctl_t;

endpackage

// File: rtl/angle_frame_deframer_unit.sv
// Angle frame deframer top level: cell row, frame checker and output register.
//
// One byte is taken per clock; the block accepts a new transaction every cycle
// unless a finished result is held waiting for out_tready. A row of eleven cells
// shifts the bytes along, and the frame check runs on the window as it will look
// after the incoming byte, so a frame ending in that byte produces its result in
// the output register in the cycle after acceptance. After a match all cells are
// marked empty and the next frame needs eleven fresh bytes.
module angle_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [15:0] angle_x_word, [31:16] angle_y_word,
                                  // [47:32] angle_z_word
);

  localparam int N = afd_pkg::WIN_LEN;

  afd_pkg::window_t  win;
  afd_pkg::window_t  cand;
  logic [N-1:0]      vld;
  logic              in_acc;
  logic              hit;
  logic              full;
  afd_pkg::afd_ctl_t ctl;

  logic        out_vld_r;
  logic        out_vld_nxt;
  logic [47:0] out_data_r;

  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Index 0 is the oldest byte, the last cell takes the incoming byte.
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == N - 1) begin : g_tail
      afd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .byte_in  (in_tdata),
        .vld_in   (1'b1),
        .byte_out (win[g]),
        .vld_out  (vld[g])
      );
    end else begin : g_body
      afd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .byte_in  (win[g+1]),
        .vld_in   (vld[g+1]),
        .byte_out (win[g]),
        .vld_out  (vld[g])
      );
    end
  end

  assign cand = {in_tdata, win[N-1:1]};
  assign full = &vld[N-1:1];

  afd_check u_check (
    .win (cand),
    .hit (hit)
  );

  assign ctl.shift = in_acc;
  assign ctl.flush = in_acc && full && hit;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (ctl.flush) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.flush) begin
      out_data_r <= {cand[10], cand[9], cand[8], cand[7], cand[6], cand[5]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Valid cells always form a run that ends at the newest cell.
  a_vld_run: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[N-2:0] & ~vld[N-1:1]) == '0)
    else $error("window valid bits are not contiguous");

  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.flush |=> (vld == '0) && out_vld_r)
    else $error("window not emptied after a frame");

  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(in_acc))
    else $error("result appeared without an input transaction");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_vld_r && !out_tready)
    else $error("input stalled with no pending result");

endmodule

// File: rtl/afd_cell.sv
// One window cell: holds a byte and a valid flag, loads from its newer neighbor.
module afd_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  afd_pkg::afd_ctl_t ctl,
  input  afd_pkg::byte_t    byte_in,
  input  logic              vld_in,
  output afd_pkg::byte_t    byte_out,
  output logic              vld_out
);

  afd_pkg::byte_t byte_r;
  logic           vld_r;
  logic           vld_nxt;

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.flush) begin
      vld_nxt = 1'b0;
    end else if (ctl.shift) begin
      vld_nxt = vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // The byte needs no clearing: a flushed cell is not read until refilled.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign vld_out  = vld_r;

endmodule

// File: rtl/afd_check.sv
// Frame checker: header compare and XOR check over a candidate window.
module afd_check (
  input  afd_pkg::window_t win,
  output logic             hit
);

  afd_pkg::byte_t chk;
  logic           hdr_ok;

  always_comb begin
    chk = '0;
    for (int k = afd_pkg::CHK_POS + 1; k < afd_pkg::WIN_LEN; k++) begin
      chk = chk ^ win[k];
    end
  end

  assign hdr_ok = (win[0] == afd_pkg::HDR_0) && (win[1] == afd_pkg::HDR_1) &&
                  (win[2] == afd_pkg::HDR_2) && (win[3] == afd_pkg::HDR_3);

  assign hit = hdr_ok && (chk == win[afd_pkg::CHK_POS]);

endmodule

// File: bench/tb.sv
// Self-checking testbench for the angle frame deframer: byte stream in, angle words out.
module tb;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_BYTES = 1018;

  typedef struct packed {
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } angle_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  afd_pkg::byte_t win [afd_pkg::WIN_LEN];
  int unsigned    win_fill;
  angle_t         angle_q [$];
  int unsigned    mismatch_cnt;
  int unsigned    sent_bytes;
  int unsigned    stall_cycles;
  bit             steady;

  angle_frame_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // While steady is set, neither side inserts idle cycles.
  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic afd_pkg::byte_t noise_byte();
    case ($urandom_range(0, 7))
      0: return afd_pkg::HDR_0;
      1: return afd_pkg::HDR_1;
      2: return afd_pkg::HDR_2;
      3: return afd_pkg::HDR_3;
      default: return afd_pkg::byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Shifts one byte into the window and queues the angles when a frame completes.
  function automatic void deframe_byte(input afd_pkg::byte_t b);
    afd_pkg::byte_t chk;
    angle_t         hit;
    for (int k = 0; k < afd_pkg::WIN_LEN - 1; k++) win[k] = win[k + 1];
    win[afd_pkg::WIN_LEN - 1] = b;
    if (win_fill < afd_pkg::WIN_LEN) win_fill++;
    chk = '0;
    for (int k = afd_pkg::CHK_POS + 1; k < afd_pkg::WIN_LEN; k++) chk ^= win[k];
    if (win_fill == afd_pkg::WIN_LEN && win[0] == afd_pkg::HDR_0 &&
        win[1] == afd_pkg::HDR_1 && win[2] == afd_pkg::HDR_2 &&
        win[3] == afd_pkg::HDR_3 && chk == win[afd_pkg::CHK_POS]) begin
      hit.x = {win[6], win[5]};
      hit.y = {win[8], win[7]};
      hit.z = {win[10], win[9]};
      angle_q.push_back(hit);
      foreach (win[k]) win[k] = '0;
      win_fill = 0;
    end
  endfunction

  // Handshake signals are stable from the falling edge to the next rising edge,
  // so the decision to accept is taken there.
  task automatic push_byte(input afd_pkg::byte_t b);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    deframe_byte(b);
    sent_bytes++;
  endtask

  // Sends count bytes of a frame starting at byte first; the check byte is XORed with flip.
  task automatic send_frame(input logic [47:0] data, input afd_pkg::byte_t flip,
                            input int first, input int count);
    afd_pkg::byte_t fr [afd_pkg::WIN_LEN];
    afd_pkg::byte_t chk;
    chk = '0;
    for (int k = 0; k < 6; k++) chk ^= data[8*k +: 8];
    fr[0] = afd_pkg::HDR_0;
    fr[1] = afd_pkg::HDR_1;
    fr[2] = afd_pkg::HDR_2;
    fr[3] = afd_pkg::HDR_3;
    fr[afd_pkg::CHK_POS] = chk ^ flip;
    for (int k = 0; k < 6; k++) fr[afd_pkg::CHK_POS + 1 + k] = data[8*k +: 8];
    for (int k = first; k < first + count; k++) push_byte(fr[k]);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (angle_q.size() != 0) @(posedge clk);
  endtask

  // Data 00 00 FF FF 00 A7 gives the word extremes and leaves A7 as the final byte.
  task automatic test_extremes();
    send_frame(48'hA700_FFFF_0000, 8'h00, 0, afd_pkg::WIN_LEN);
  endtask

  // These ten bytes would complete a frame with the A7 left over from the last one,
  // but the window was flushed, so nothing may come out.
  task automatic test_no_overlap();
    send_frame(48'h1234_5678_9ABC, 8'h00, 1, afd_pkg::WIN_LEN - 1);
  endtask

  task automatic test_bad_check();
    send_frame(48'h0102_0408_1020, 8'h01, 0, afd_pkg::WIN_LEN);
  endtask

  task automatic test_random_stream();
    int unsigned target;
    int unsigned kind;
    logic [47:0] data;
    bit          paused;
    target = sent_bytes + RANDOM_BYTES;
    paused = 1'b0;
    while (sent_bytes < target) begin
      if ($urandom_range(0, 7) == 0) steady = !steady;
      if (!paused && sent_bytes >= target - RANDOM_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
      data = {16'($urandom()), $urandom()};
      for (int k = 0; k < 6; k++)
        if ($urandom_range(0, 3) == 0) data[8*k +: 8] = noise_byte();
      kind = $urandom_range(0, 19);
      if (kind < 11) begin
        repeat ($urandom_range(0, 2)) push_byte(noise_byte());
        send_frame(data, 8'h00, 0, afd_pkg::WIN_LEN);
      end else if (kind < 14) begin
        send_frame(data, afd_pkg::byte_t'($urandom_range(1, 255)), 0, afd_pkg::WIN_LEN);
      end else if (kind < 16) begin
        send_frame(data, 8'h00, 0, $urandom_range(1, afd_pkg::WIN_LEN - 1));
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(noise_byte());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    foreach (win[k]) win[k] = '0;
    win_fill     = 0;
    mismatch_cnt = 0;
    sent_bytes   = 0;
    steady       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_no_overlap();
    test_bad_check();
    test_random_stream();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random back-pressure, and every transaction is checked against the queue.
  initial begin : result_check
    int unsigned stall;
    angle_t      got;
    angle_t      want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      got = out_tdata;
      @(posedge clk);
      if (angle_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("tb: result with none expected: x=%h y=%h z=%h", got.x, got.y, got.z);
      end else begin
        want = angle_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("tb: angle mismatch: x exp %h got %h, y exp %h got %h, z exp %h got %h",
                     want.x, got.x, want.y, got.y, want.z, got.z);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial stall_cycles = 0;

endmodule

// File: files.f
rtl/afd_pkg.sv
rtl/afd_cell.sv
rtl/afd_check.sv
rtl/angle_frame_deframer_unit.sv
bench/tb.sv
